// ----- rtl/rosd_pkg.sv -----
// Shared types and codes for the rebase opcode stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package rosd_pkg;

   localparam int MAX_SEGMENTS = 16;
   localparam int PTR_BYTES    = 8;
   localparam int RSP_DATA_W   = 208;
   localparam int CSR_INDEX_W  = 3;

   typedef enum logic [1:0] {
      PHASE_OPCODE,
      PHASE_FIRST,
      PHASE_SECOND
   } phase_type;

   typedef enum logic [1:0] {
      KIND_RUN     = 2'd0,
      KIND_DONE    = 2'd1,
      KIND_UNKNOWN = 2'd2,
      KIND_BADSEG  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      REGION_EXEC     = 2'd0,
      REGION_WRITE    = 2'd1,
      REGION_READONLY = 2'd2
   } region_type;

   localparam logic [3:0] OP_DONE          = 4'h0;
   localparam logic [3:0] OP_SET_TYPE      = 4'h1;
   localparam logic [3:0] OP_SET_SEG_ULEB  = 4'h2;
   localparam logic [3:0] OP_ADD_ULEB      = 4'h3;
   localparam logic [3:0] OP_ADD_IMM       = 4'h4;
   localparam logic [3:0] OP_RUN_IMM       = 4'h5;
   localparam logic [3:0] OP_RUN_ULEB      = 4'h6;
   localparam logic [3:0] OP_RUN_ADD_ULEB  = 4'h7;
   localparam logic [3:0] OP_RUN_SKIP_ULEB = 4'h8;

   localparam logic [CSR_INDEX_W-1:0] CSR_SEGMENT_COUNT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_MAP     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXEC_BASE      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WRITE_BASE     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_READONLY_BASE  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_NUMBER   = 3'd5;

endpackage

`default_nettype wire

// ----- rtl/rebase_opcode_stream_decoder_core.sv -----
// Top level: rebase opcode stream decoder, byte in, run/done/error request out.
//
//   channel | ports           | payload
//   --------+-----------------+---------------------------------------------
//   req     | req_t*          | tdata: stream_byte; tlast: end_of_stream
//   rsp     | rsp_t*          | tuser: result_kind; tdata: region, start_offset,
//           |                 |   run_count, run_stride, source_image
//   csr     | csr_valid/ready | csr_index, csr_data (64 bits)
//
// One byte per cycle sustained while rsp is not stalled; a byte passes the input
// register, then decode into the result register. The decode step is set by the
// operand multiply-accumulate of the skip-run opcode, which is folded in seven
// bits per operand byte. Reset is synchronous and clears the configuration, the
// decode state and the valid flags, not the payload registers. A stalled rsp
// holds the result register and backs up into req one request later.
`timescale 1ns / 1ps
`default_nettype none

module rebase_opcode_stream_decoder_core
   import rosd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,   // [7:0] stream_byte
   input  wire logic                   req_tlast,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,   // [1:0] region, [65:2] start_offset,
                                                    // [129:66] run_count,
                                                    // [193:130] run_stride,
                                                    // [200:194] source_image, rest 0
   output logic [1:0]                  rsp_tuser,   // [1:0] result_kind
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [63:0]            csr_data
);

   // configuration
   logic [4:0]  seg_count_ff;
   logic [31:0] region_map_ff;
   logic [63:0] exec_base_ff;
   logic [63:0] write_base_ff;
   logic [63:0] ro_base_ff;
   logic [6:0]  image_ff;

   // input register
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;

   // decode state
   phase_type   phase_ff, phase_in;
   logic [3:0]  pending_ff, pending_in;
   logic [3:0]  segment_ff, segment_in;
   logic [63:0] offset_ff, offset_in;
   logic [63:0] leb_ff, leb_in;
   logic [6:0]  shift_ff, shift_in;
   logic [63:0] first_ff, first_in;
   logic [63:0] prod_ff, prod_in;     // 8*first + first*second so far
   logic        halted_ff, halted_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   kind_type    rsp_kind_ff, rsp_kind_in;
   logic [1:0]  rsp_region_ff, rsp_region_in;
   logic [63:0] rsp_start_ff, rsp_start_in;
   logic [63:0] rsp_count_ff, rsp_count_in;
   logic [63:0] rsp_stride_ff, rsp_stride_in;

   logic        fire;
   logic [3:0]  op;
   logic [3:0]  imm;
   logic [6:0]  chunk;
   logic        chunk_live;
   logic [63:0] leb_new;
   logic [63:0] mul_lo;
   logic [63:0] prod_new;

   logic        exec_req;
   logic [3:0]  exec_op;
   logic [63:0] exec_a;
   logic [63:0] exec_b;
   logic        exec_second;
   logic        run_req;
   logic [63:0] run_cnt;
   logic [63:0] run_str;
   logic [63:0] run_adv;
   logic [1:0]  map_code;
   logic        seg_bad;

   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign csr_ready  = 1'b1;

   assign op    = in_byte_ff[7:4];
   assign imm   = in_byte_ff[3:0];
   assign chunk = in_byte_ff[6:0];
   assign chunk_live = !shift_ff[6];

   // operand byte folded into the LEB value and into the skip-run product
   assign mul_lo   = 64'(first_ff * {57'd0, chunk});
   assign leb_new  = leb_ff | (chunk_live ? ({57'd0, chunk} << shift_ff[5:0]) : 64'd0);
   assign prod_new = prod_ff + (chunk_live ? (mul_lo << shift_ff[5:0]) : 64'd0);

   assign map_code = region_map_ff[{segment_ff, 1'b0} +: 2];
   assign seg_bad  = ({1'b0, segment_ff} >= seg_count_ff) ||
                     ({1'b0, segment_ff} >= 5'(MAX_SEGMENTS));

   always_comb begin
      phase_in      = phase_ff;
      pending_in    = pending_ff;
      segment_in    = segment_ff;
      offset_in     = offset_ff;
      leb_in        = leb_ff;
      shift_in      = shift_ff;
      first_in      = first_ff;
      prod_in       = prod_ff;
      halted_in     = halted_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_region_in = rsp_region_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_stride_in = rsp_stride_ff;
      exec_req      = 1'b0;
      exec_op       = pending_ff;
      exec_a        = 64'd0;
      exec_b        = 64'd0;
      exec_second   = 1'b0;
      run_req       = 1'b0;
      run_cnt       = 64'd0;
      run_str       = 64'(PTR_BYTES);
      run_adv       = 64'd0;

      if (fire) begin
         rsp_valid_in  = 1'b0;
         rsp_kind_in   = KIND_RUN;
         rsp_region_in = REGION_EXEC;
         rsp_start_in  = 64'd0;
         rsp_count_in  = 64'd0;
         rsp_stride_in = 64'd0;

         if (!halted_ff) begin
            if (phase_ff == PHASE_OPCODE) begin
               unique case (op)
                  OP_DONE: begin
                     halted_in    = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_DONE;
                  end
                  OP_SET_TYPE: begin
                  end
                  OP_ADD_IMM: begin
                     offset_in = offset_ff + {57'd0, imm, 3'd0};
                  end
                  OP_RUN_IMM: begin
                     run_req = 1'b1;
                     run_cnt = {60'd0, imm};
                     run_adv = {57'd0, imm, 3'd0};
                  end
                  OP_SET_SEG_ULEB, OP_ADD_ULEB, OP_RUN_ULEB, OP_RUN_ADD_ULEB,
                  OP_RUN_SKIP_ULEB: begin
                     if (op == OP_SET_SEG_ULEB) begin
                        segment_in = imm;
                     end
                     pending_in = op;
                     phase_in   = PHASE_FIRST;
                     leb_in     = 64'd0;
                     shift_in   = 7'd0;
                     // stream ends before the operand: operand counts as zero
                     if (in_last_ff) begin
                        phase_in = PHASE_OPCODE;
                        exec_req = 1'b1;
                        exec_op  = op;
                     end
                  end
                  default: begin
                     halted_in    = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_UNKNOWN;
                  end
               endcase
            end else begin
               leb_in   = leb_new;
               shift_in = chunk_live ? shift_ff + 7'd7 : shift_ff;
               prod_in  = prod_new;
               if (!in_byte_ff[7] || in_last_ff) begin
                  leb_in   = 64'd0;
                  shift_in = 7'd0;
                  if (phase_ff == PHASE_FIRST && pending_ff == OP_RUN_SKIP_ULEB &&
                      !in_last_ff) begin
                     first_in = leb_new;
                     phase_in = PHASE_SECOND;
                     prod_in  = {leb_new[60:0], 3'd0};
                  end else begin
                     phase_in    = PHASE_OPCODE;
                     exec_req    = 1'b1;
                     exec_second = (phase_ff == PHASE_SECOND);
                     exec_a      = exec_second ? first_ff : leb_new;
                     exec_b      = exec_second ? leb_new : 64'd0;
                  end
               end
            end
         end

         if (exec_req) begin
            unique case (exec_op)
               OP_SET_SEG_ULEB: offset_in = exec_a;
               OP_ADD_ULEB:     offset_in = offset_ff + exec_a;
               OP_RUN_ULEB: begin
                  run_req = 1'b1;
                  run_cnt = exec_a;
                  run_adv = {exec_a[60:0], 3'd0};
               end
               OP_RUN_ADD_ULEB: begin
                  run_req = 1'b1;
                  run_cnt = 64'd1;
                  run_str = exec_a + 64'(PTR_BYTES);
                  run_adv = exec_a + 64'(PTR_BYTES);
               end
               OP_RUN_SKIP_ULEB: begin
                  run_req = 1'b1;
                  run_cnt = exec_a;
                  run_str = exec_b + 64'(PTR_BYTES);
                  run_adv = exec_second ? prod_new : {exec_a[60:0], 3'd0};
               end
               default: begin
               end
            endcase
         end

         // an empty run gives nothing, not even a segment check
         if (run_req && run_cnt != 64'd0) begin
            rsp_valid_in = 1'b1;
            if (seg_bad) begin
               halted_in   = 1'b1;
               rsp_kind_in = KIND_BADSEG;
            end else begin
               rsp_kind_in   = KIND_RUN;
               rsp_count_in  = run_cnt;
               rsp_stride_in = run_str;
               offset_in     = offset_ff + run_adv;
               unique case (map_code)
                  REGION_EXEC: begin
                     rsp_region_in = REGION_EXEC;
                     rsp_start_in  = exec_base_ff + offset_ff;
                  end
                  REGION_WRITE: begin
                     rsp_region_in = REGION_WRITE;
                     rsp_start_in  = write_base_ff + offset_ff;
                  end
                  default: begin
                     rsp_region_in = REGION_READONLY;
                     rsp_start_in  = ro_base_ff + offset_ff;
                  end
               endcase
            end
         end

         if (in_last_ff) begin
            phase_in   = PHASE_OPCODE;
            pending_in = 4'd0;
            segment_in = 4'd0;
            offset_in  = 64'd0;
            leb_in     = 64'd0;
            shift_in   = 7'd0;
            first_in   = 64'd0;
            prod_in    = 64'd0;
            halted_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_count_ff  <= 5'd0;
         region_map_ff <= 32'd0;
         exec_base_ff  <= 64'd0;
         write_base_ff <= 64'd0;
         ro_base_ff    <= 64'd0;
         image_ff      <= 7'd0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SEGMENT_COUNT: seg_count_ff  <= csr_data[4:0];
            CSR_REGION_MAP:    region_map_ff <= csr_data[31:0];
            CSR_EXEC_BASE:     exec_base_ff  <= csr_data;
            CSR_WRITE_BASE:    write_base_ff <= csr_data;
            CSR_READONLY_BASE: ro_base_ff    <= csr_data;
            CSR_IMAGE_NUMBER:  image_ff      <= csr_data[6:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_OPCODE;
         pending_ff   <= 4'd0;
         segment_ff   <= 4'd0;
         offset_ff    <= 64'd0;
         leb_ff       <= 64'd0;
         shift_ff     <= 7'd0;
         first_ff     <= 64'd0;
         prod_ff      <= 64'd0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pending_ff   <= pending_in;
         segment_ff   <= segment_in;
         offset_ff    <= offset_in;
         leb_ff       <= leb_in;
         shift_ff     <= shift_in;
         first_ff     <= first_in;
         prod_ff      <= prod_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_kind_ff   <= rsp_kind_in;
      rsp_region_ff <= rsp_region_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_stride_ff <= rsp_stride_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {7'd0, image_ff, rsp_stride_ff, rsp_count_ff, rsp_start_ff,
                        rsp_region_ff};

endmodule

`default_nettype wire

// ----- rtl/rosd_checker.sv -----
// Port-level checks for the rebase opcode stream decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rosd_port_checks
   import rosd_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [1:0]            rsp_tuser
);

   // a stalled request keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // done and error requests carry no run
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_RUN |-> rsp_tdata[193:0] == '0)
      else $error("non-run request with run fields");

   // a run names a real region and has a nonzero count
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_RUN |->
         rsp_tdata[1:0] != 2'd3 && rsp_tdata[129:66] != 64'd0)
      else $error("run with bad region or empty count");

endmodule

bind rebase_opcode_stream_decoder_core rosd_port_checks u_rosd_port_checks (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
